// ===== hw/rtl/stcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcr_pkg
// Shared types and constants of the square tile crop and rotate unit.
// ----------------------------------------------------------------------------
package stcr_pkg;

  // sizing
  localparam int MAX_SIDE    = 64;
  localparam int MAX_WIDTH   = 4096;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int IDX_W   = $clog2(MAX_SIDE);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int TOTAL_W = $clog2(STORE_DEPTH + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WSAT_W  = COL_W + 1;

  // fixed register and field widths
  localparam int WIDTH_REG_W = 13;
  localparam int OFS_W       = 12;
  localparam int SIDE_REG_W  = 7;
  localparam int ROT_W       = 2;
  localparam int ROW_W       = 12;
  localparam int PIX_W       = 32;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int CMP_W       = (COL_W > OFS_W) ? COL_W : OFS_W;

  localparam logic [ROW_W-1:0] ROW_TOP = {ROW_W{1'b1}};

  // reset values after saturation
  localparam int WIDTH_RST = 64;
  localparam int SIDE_RST  = (64 > MAX_SIDE) ? MAX_SIDE : 64;
  localparam int TOTAL_RST = SIDE_RST * SIDE_RST;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH = 3'd0,
    REG_X_OFFSET  = 3'd1,
    REG_Y_OFFSET  = 3'd2,
    REG_SIDE      = 3'd3,
    REG_ROTATION  = 3'd4
  } reg_idx_t;

  typedef enum logic [ROT_W-1:0] {
    ROT_COPY = 2'd0,
    ROT_CCW  = 2'd1,
    ROT_HALF = 2'd2,
    ROT_CW   = 2'd3
  } rot_code_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic             opcode;
    logic             frame_start;
    logic [PIX_W-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             out_valid;
    logic             out_last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
    logic              last;
  } cmd_t;

endpackage

// ===== hw/rtl/stcr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcr_front
// Configuration registers, raster counters and tile address generation.
// Turns each accepted pull, and each accepted push kept for the tile, into a store command.
// ----------------------------------------------------------------------------
module stcr_front import stcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  input  logic                  q_ready
);

  logic [WSAT_W-1:0]  wsat_r;
  logic [OFS_W-1:0]   x_off_r;
  logic [OFS_W-1:0]   y_off_r;
  logic [SIDE_W-1:0]  side_r;
  logic [TOTAL_W-1:0] total_r;
  rot_code_t          rot_r;

  logic [COL_W-1:0]   col_r,  col_nxt;
  logic [ROW_W-1:0]   row_r,  row_nxt;
  logic [TOTAL_W-1:0] kept_r, kept_nxt;
  logic [ADDR_W-1:0]  rp_r,   rp_nxt;

  logic [SIDE_REG_W-1:0]  side_raw;
  logic [WIDTH_REG_W-1:0] width_raw;
  logic [SIDE_W-1:0]      side_w;
  logic [WSAT_W-1:0]      width_w;

  logic [COL_W-1:0]   col_cur;
  logic [ROW_W-1:0]   row_cur;
  logic [TOTAL_W-1:0] kept_cur;
  logic [ADDR_W-1:0]  rp_cur, rp_eff;
  logic [CMP_W-1:0]   col_ext, x_ext, dx;
  logic [ROW_W-1:0]   dy;
  logic               in_win, keep, tile_full, rd_last;
  logic [IDX_W-1:0]   i_idx, c_idx, sm1, r_sel, q_sel;
  logic [IDX_W+SIDE_W-1:0] prod;
  logic [ADDR_W-1:0]  wr_addr;
  logic [WSAT_W-1:0]  col_inc;
  logic [TOTAL_W-1:0] rp_inc;
  logic               accept;

  // saturate register writes on the way in
  always_comb begin
    side_raw  = cfg_wdata[SIDE_REG_W-1:0];
    width_raw = cfg_wdata[WIDTH_REG_W-1:0];
    if (side_raw == '0) begin
      side_w = SIDE_W'(1);
    end else if (int'(side_raw) > MAX_SIDE) begin
      side_w = SIDE_W'(MAX_SIDE);
    end else begin
      side_w = SIDE_W'(side_raw);
    end
    if (width_raw == '0) begin
      width_w = WSAT_W'(1);
    end else if (int'(width_raw) > MAX_WIDTH) begin
      width_w = WSAT_W'(MAX_WIDTH);
    end else begin
      width_w = WSAT_W'(width_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsat_r  <= WSAT_W'(WIDTH_RST);
      x_off_r <= '0;
      y_off_r <= '0;
      side_r  <= SIDE_W'(SIDE_RST);
      total_r <= TOTAL_W'(TOTAL_RST);
      rot_r   <= ROT_COPY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH: wsat_r  <= width_w;
        REG_X_OFFSET:  x_off_r <= cfg_wdata[OFS_W-1:0];
        REG_Y_OFFSET:  y_off_r <= cfg_wdata[OFS_W-1:0];
        REG_SIDE: begin
          side_r  <= side_w;
          total_r <= TOTAL_W'(side_w) * TOTAL_W'(side_w);
        end
        REG_ROTATION:  rot_r   <= rot_code_t'(cfg_wdata[ROT_W-1:0]);
        default: ;
      endcase
    end
  end

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    col_cur  = in_data.frame_start ? '0 : col_r;
    row_cur  = in_data.frame_start ? '0 : row_r;
    kept_cur = in_data.frame_start ? '0 : kept_r;
    rp_cur   = in_data.frame_start ? '0 : rp_r;

    // window test
    col_ext = CMP_W'(col_cur);
    x_ext   = CMP_W'(x_off_r);
    dx      = col_ext - x_ext;
    dy      = row_cur - y_off_r;
    in_win  = (col_ext >= x_ext) && (dx < CMP_W'(side_r)) &&
              (row_cur >= y_off_r) && (dy < ROW_W'(side_r));
    keep    = in_win && (kept_cur < total_r);

    // tile address: row select times side plus column select
    i_idx = IDX_W'(dy);
    c_idx = IDX_W'(dx);
    sm1   = IDX_W'(side_r - SIDE_W'(1));
    unique case (rot_r)
      ROT_COPY: begin r_sel = i_idx;         q_sel = c_idx;         end
      ROT_CCW:  begin r_sel = sm1 - c_idx;   q_sel = i_idx;         end
      ROT_HALF: begin r_sel = sm1 - i_idx;   q_sel = sm1 - c_idx;   end
      ROT_CW:   begin r_sel = c_idx;         q_sel = sm1 - i_idx;   end
      default:  begin r_sel = i_idx;         q_sel = c_idx;         end
    endcase
    prod    = (IDX_W + SIDE_W)'(r_sel) * (IDX_W + SIDE_W)'(side_r);
    wr_addr = ADDR_W'(prod + (IDX_W + SIDE_W)'(q_sel));

    // read side
    tile_full = (kept_cur >= total_r);
    rp_eff    = (TOTAL_W'(rp_cur) >= total_r) ? '0 : rp_cur;
    rp_inc    = TOTAL_W'(rp_eff) + TOTAL_W'(1);
    rd_last   = (rp_inc >= total_r);

    col_inc  = WSAT_W'(col_cur) + WSAT_W'(1);
    col_nxt  = col_cur;
    row_nxt  = row_cur;
    kept_nxt = kept_cur;
    rp_nxt   = rp_cur;
    q_push   = 1'b0;
    q_cmd    = '{kind: CMD_EMPTY, addr: '0, data: '0, last: 1'b0};

    if (in_data.opcode == OP_PUSH) begin
      if (keep) begin
        kept_nxt = kept_cur + TOTAL_W'(1);
        q_push   = accept;
        q_cmd    = '{kind: CMD_WRITE, addr: wr_addr, data: in_data.pixel, last: 1'b0};
      end
      if (col_inc >= wsat_r) begin
        col_nxt = '0;
        if (row_cur != ROW_TOP) begin
          row_nxt = row_cur + ROW_W'(1);
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end else begin
      q_push = accept;
      if (tile_full) begin
        q_cmd  = '{kind: CMD_READ, addr: rp_eff, data: '0, last: rd_last};
        rp_nxt = rd_last ? '0 : rp_inc[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      kept_r <= '0;
      rp_r   <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      kept_r <= kept_nxt;
      rp_r   <= rp_nxt;
    end
  end

endmodule

// ===== hw/rtl/stcr_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcr_cmd_fifo
// Short command queue that decouples the front from the tile store.
// ----------------------------------------------------------------------------
module stcr_cmd_fifo import stcr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  output logic avail,
  output cmd_t head,
  input  logic pop
);

  cmd_t                  slot_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] count_r;

  assign ready = (count_r != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign avail = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == CMDQ_DEPTH - 1) ? '0 : wr_ptr_r + CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == CMDQ_DEPTH - 1) ? '0 : rd_ptr_r + CMDQ_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CMDQ_CNT_W'(1);
        2'b01:   count_r <= count_r - CMDQ_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CMDQ_CNT_W'(CMDQ_DEPTH)) || pop)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("command queue underflow");

endmodule

// ===== hw/rtl/stcr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stcr_back
// Tile store and readout: executes queued writes, reads and empty pulls, registers the
// memory data and holds the result in an output register.
// ----------------------------------------------------------------------------
module stcr_back import stcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_avail,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [PIX_W-1:0] mem_r [STORE_DEPTH];
  logic [PIX_W-1:0] rd_data_r;

  logic      p1_v_r;
  logic      p1_empty_r;
  logic      p1_last_r;
  logic      out_v_r;
  out_item_t out_r;

  logic p1_adv;
  logic is_write;

  assign p1_adv   = p1_v_r && (!out_v_r || out_ready);
  assign is_write = (q_head.kind == CMD_WRITE);
  // writes never occupy the read stage
  assign q_pop    = q_avail && (is_write || !p1_v_r || p1_adv);

  always_ff @(posedge clk) begin
    if (q_pop && is_write) begin
      mem_r[q_head.addr] <= q_head.data;
    end
    if (q_pop && (q_head.kind == CMD_READ)) begin
      rd_data_r <= mem_r[q_head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !is_write) begin
      p1_empty_r <= (q_head.kind != CMD_READ);
      p1_last_r  <= q_head.last;
    end
    if (p1_adv) begin
      out_r.out_pixel <= p1_empty_r ? '0 : rd_data_r;
      out_r.out_valid <= !p1_empty_r;
      out_r.out_last  <= !p1_empty_r && p1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop && !is_write) begin
        p1_v_r <= 1'b1;
      end else if (p1_adv) begin
        p1_v_r <= 1'b0;
      end
      if (p1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.out_valid |-> out_r.out_pixel == '0 && !out_r.out_last)
    else $error("not-valid result carries data");

  a_read_stage_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && !is_write && p1_v_r |-> p1_adv)
    else $error("read issued into a busy stage");

endmodule

// ===== hw/rtl/square_tile_crop_rotate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_tile_crop_rotate_unit
// Crops a square window from a raster pixel stream into a rotated tile store
// and reads the tile back in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one transaction per pixel push (opcode 0) or tile
//   pull (opcode 1); frame_start marks the first pixel of a frame.
//   out_valid/out_ready carry one result per pull; a push gives none.
//   cfg_we/cfg_index/cfg_wdata write the five registers, only while idle.
// Throughput: one transaction per cycle on both channels, sustained while out_ready stays high.
// Path: a pull's result reaches out_valid through the command queue slot, the
//   store read register and the output register.
// The front computes the tile address in the cycle of acceptance with one
// small multiplier; the tile store has one port, used by one command a cycle.
// A pull before the tile is full returns a result with out_valid 0.
// Reset clears counters and restores register defaults; the tile store keeps
// no reset and needs no clearing pass.
// When the receiver stalls, the output register holds, the read stage and a
// 4-entry command queue fill, and in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module square_tile_crop_rotate_unit import stcr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  logic q_push, q_ready, q_avail, q_pop;
  cmd_t q_cmd, q_head;

  stcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_push    (q_push),
    .q_cmd     (q_cmd),
    .q_ready   (q_ready)
  );

  stcr_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .ready    (q_ready),
    .avail    (q_avail),
    .head     (q_head),
    .pop      (q_pop)
  );

  stcr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/tb_square_tile_crop_rotate_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_tile_crop_rotate_unit
// Pushes raster frames through the crop and rotate unit and pulls the tiles
// back. A directed table covers reset, saturated sizes, early pulls, read wrap
// and a window off the image. Short frames then hit the register extremes, and
// random frames run under four idle and stall mixes. Every pull result is checked against
// an in-bench model of the tile store or, in typed rows, against the table's expected result.
// ----------------------------------------------------------------------------
module tb_square_tile_crop_rotate_unit;
  import stcr_pkg::*;

  localparam int QUIET_CYCLES = 12;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0] w;
    logic [OFS_W-1:0]       x;
    logic [OFS_W-1:0]       y;
    logic [SIDE_REG_W-1:0]  s;
    rot_code_t              r;
  } window_cfg_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    in_item_t    item;
    logic        typed;
    out_item_t   want;
    window_cfg_t cfg;
  } stim_row_t;

  localparam in_item_t    NO_ITEM       = '0;
  localparam window_cfg_t NO_CFG        = '0;
  localparam out_item_t   RES_IDLE      = '0;
  localparam out_item_t   RES_ONES_LAST = '{32'hFFFF_FFFF, 1'b1, 1'b1};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  square_tile_crop_rotate_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned fail_count     = 0;

  out_item_t expected_reads[$];

  // tile model state
  window_cfg_t      win_cfg     = '{13'd64, 12'd0, 12'd0, 7'd64, ROT_COPY};
  logic [COL_W-1:0]   src_col     = '0;
  logic [ROW_W-1:0]   src_row     = '0;
  logic [TOTAL_W-1:0] kept_pixels = '0;
  logic [ADDR_W-1:0]  read_ptr    = '0;
  logic [PIX_W-1:0]   tile_image [STORE_DEPTH];

  stim_row_t dir_rows [25];

  function automatic int unsigned side_eff(window_cfg_t c);
    if (c.s == 0) return 1;
    if (c.s > MAX_SIDE) return MAX_SIDE;
    return 32'(c.s);
  endfunction

  function automatic int unsigned width_eff(window_cfg_t c);
    if (c.w == 0) return 1;
    if (c.w > MAX_WIDTH) return MAX_WIDTH;
    return 32'(c.w);
  endfunction

  function automatic void predict_access(input in_item_t it, output bit has_res,
                                         output out_item_t res);
    int unsigned s, total, w, i, c, a;
    s = side_eff(win_cfg);
    total = s * s;
    has_res = 1'b0;
    res = RES_IDLE;
    if (it.frame_start) begin
      src_col = '0;
      src_row = '0;
      kept_pixels = '0;
      read_ptr = '0;
    end
    if (it.opcode == OP_PUSH) begin
      w = width_eff(win_cfg);
      if (src_col >= win_cfg.x && src_col - win_cfg.x < s &&
          src_row >= win_cfg.y && src_row - win_cfg.y < s && kept_pixels < total) begin
        i = src_row - win_cfg.y;
        c = src_col - win_cfg.x;
        case (win_cfg.r)
          ROT_COPY: a = i * s + c;
          ROT_CCW:  a = (s - 1 - c) * s + i;
          ROT_HALF: a = (s - 1 - i) * s + (s - 1 - c);
          default:  a = c * s + (s - 1 - i);
        endcase
        tile_image[ADDR_W'(a)] = it.pixel;
        kept_pixels++;
      end
      if (src_col + 1 >= w) begin
        src_col = '0;
        if (src_row < ROW_TOP) src_row++;
      end else begin
        src_col++;
      end
    end else begin
      has_res = 1'b1;
      if (kept_pixels >= total) begin
        if (read_ptr >= total) read_ptr = '0;
        res.out_pixel = tile_image[read_ptr];
        res.out_valid = 1'b1;
        if (read_ptr + 1 >= total) begin
          res.out_last = 1'b1;
          read_ptr = '0;
        end else begin
          read_ptr++;
        end
      end
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] reg_value(window_cfg_t c, reg_idx_t ri);
    case (ri)
      REG_SRC_WIDTH: return c.w;
      REG_X_OFFSET:  return CFG_DATA_W'(c.x);
      REG_Y_OFFSET:  return CFG_DATA_W'(c.y);
      REG_SIDE:      return CFG_DATA_W'(c.s);
      default:       return CFG_DATA_W'(c.r);
    endcase
  endfunction

  task automatic log_failure(string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endtask

  task automatic send_transaction(in_item_t it, bit typed, out_item_t want);
    bit        has_res;
    out_item_t res;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_access(it, has_res, res);
    if (has_res) expected_reads.push_back(typed ? want : res);
    items_sent++;
  endtask

  // pushes leave no result behind, so give the pipeline time after the last read
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic program_window(window_cfg_t cs);
    reg_idx_t ri;
    wait_quiet();
    ri = ri.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= ri;
      cfg_wdata <= reg_value(cs, ri);
      @(posedge clk);
      ri = ri.next();
    end while (ri != ri.first());
    cfg_we  <= 1'b0;
    win_cfg = cs;
  endtask

  task automatic play_frame(int unsigned n_push, int unsigned n_pull,
                            int unsigned early_pct, bit start_on_pull);
    in_item_t it;
    if (start_on_pull) begin
      it = '{OP_PULL, 1'b1, $urandom};
      send_transaction(it, 1'b0, RES_IDLE);
    end
    for (int unsigned p = 0; p < n_push; p++) begin
      while ($urandom_range(99) < early_pct) begin
        it = '{OP_PULL, 1'b0, $urandom};
        send_transaction(it, 1'b0, RES_IDLE);
      end
      it = '{OP_PUSH, (p == 0) && !start_on_pull, $urandom};
      send_transaction(it, 1'b0, RES_IDLE);
    end
    repeat (n_pull) begin
      it = '{OP_PULL, 1'b0, $urandom};
      send_transaction(it, 1'b0, RES_IDLE);
    end
  endtask

  task automatic run_random_frame();
    window_cfg_t cs;
    int unsigned s, w, need, n_push;
    cs = win_cfg;
    if ($urandom_range(2) != 0 || side_eff(cs) > 8 || width_eff(cs) > 12) begin
      s = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 5);
      w = $urandom_range(s, 12);
      cs.w = WIDTH_REG_W'(w);
      cs.s = SIDE_REG_W'(s);
      cs.x = OFS_W'($urandom_range(0, w - s));
      cs.y = OFS_W'($urandom_range(0, 3));
      cs.r = rot_code_t'($urandom_range(3));
      // window partly off the image now and then
      if ($urandom_range(9) == 0) cs.x = OFS_W'($urandom_range(w - s, 15));
      if (s == 1 && $urandom_range(1) != 0) cs.s = '0;
      program_window(cs);
    end
    s = side_eff(cs);
    w = width_eff(cs);
    need = (cs.y + s) * w;
    n_push = need + $urandom_range(0, w);
    // abandoned frame
    if ($urandom_range(7) == 0) n_push = $urandom_range(1, need);
    play_frame(n_push, s * s + $urandom_range(0, s * s), 10, $urandom_range(15) == 0);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : read_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reads.size() == 0) begin
        log_failure($sformatf("unexpected read result pixel %h valid %b last %b",
                              out_data.out_pixel, out_data.out_valid, out_data.out_last));
      end else begin
        want = expected_reads.pop_front();
        if (out_data.out_pixel !== want.out_pixel || out_data.out_valid !== want.out_valid ||
            out_data.out_last !== want.out_last) begin
          log_failure($sformatf("read mismatch: expected pixel %h valid %b last %b, got %h %b %b",
                                want.out_pixel, want.out_valid, want.out_last,
                                out_data.out_pixel, out_data.out_valid, out_data.out_last));
        end
      end
    end
  end

  initial begin
    int unsigned target;
    dir_rows = '{
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b1, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PUSH, 1'b1, 32'hFFFF_FFFF}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b1, RES_IDLE, NO_CFG},
      '{ROW_CFG, NO_ITEM, 1'b0, RES_IDLE, '{13'd0, 12'd0, 12'd0, 7'd0, ROT_COPY}},
      '{ROW_ITEM, '{OP_PUSH, 1'b1, 32'hFFFF_FFFF}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b1, RES_ONES_LAST, NO_CFG},
      '{ROW_ITEM, '{OP_PUSH, 1'b0, 32'h0000_0000}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b1, RES_ONES_LAST, NO_CFG},
      '{ROW_ITEM, '{OP_PULL, 1'b1, 32'hFFFF_FFFF}, 1'b1, RES_IDLE, NO_CFG},
      '{ROW_CFG, NO_ITEM, 1'b0, RES_IDLE, '{13'd2, 12'd0, 12'd0, 7'd2, ROT_CCW}},
      '{ROW_ITEM, '{OP_PUSH, 1'b1, 32'h0123_4567}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PUSH, 1'b0, 32'h89AB_CDEF}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PUSH, 1'b0, 32'h7654_3210}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PUSH, 1'b0, 32'hFEDC_BA98}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b0, RES_IDLE, NO_CFG},
      // shrink the side while the read pointer sits past the new end
      '{ROW_CFG, NO_ITEM, 1'b0, RES_IDLE, '{13'd2, 12'd0, 12'd0, 7'd1, ROT_CCW}},
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b0, RES_IDLE, NO_CFG},
      // window runs off the right edge, tile never fills
      '{ROW_CFG, NO_ITEM, 1'b0, RES_IDLE, '{13'd2, 12'd1, 12'd0, 7'd2, ROT_CW}},
      '{ROW_ITEM, '{OP_PUSH, 1'b1, 32'h5A5A_5A5A}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PUSH, 1'b0, 32'hA5A5_A5A5}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PUSH, 1'b0, 32'hC3C3_C3C3}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PUSH, 1'b0, 32'h3C3C_3C3C}, 1'b0, RES_IDLE, NO_CFG},
      '{ROW_ITEM, '{OP_PULL, 1'b0, 32'h0000_0000}, 1'b1, RES_IDLE, NO_CFG}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < $size(dir_rows); k++) begin
      if (dir_rows[k].kind == ROW_CFG) program_window(dir_rows[k].cfg);
      else send_transaction(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    end

    // register extremes: widest image, last column and row, largest side
    program_window('{13'h1FFF, 12'd4095, 12'd4095, 7'h7F, ROT_CW});
    play_frame(48, 3, 0, 1'b0);
    program_window('{13'd1, 12'd0, 12'd0, 7'h7F, ROT_HALF});
    play_frame(40, 2, 0, 1'b0);

    for (int mode = 0; mode < 4; mode++) begin
      send_idle_pct  = (mode == 1) ? 74 : (mode == 3) ? 33 : 0;
      recv_stall_pct = (mode == 2) ? 74 : (mode == 3) ? 33 : 0;
      target = items_sent + 215;
      while (items_sent < target) run_random_frame();
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
